// File: hw/rtl/font_position_reverse_translator_unit_defines.svh
// Assertion macros for the font position reverse translator.
// Taken in by the modules that carry concurrent checks; no dependencies.
`ifndef FONT_POSITION_REVERSE_TRANSLATOR_UNIT_DEFINES_SVH
`define FONT_POSITION_REVERSE_TRANSLATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FPRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define FPRT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FPRT_ASSERT(lbl, prop, msg)
`define FPRT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/fprt_pkg.sv
// Shared types and constants for the font position reverse translator.
// No dependencies; used by the controller, datapath and top level.
package fprt_pkg;

    localparam int CHAR_MAP_DEPTH     = 256;
    localparam int REV_DEPTH          = 512;
    localparam int REV_AW             = 9;
    localparam int FONT_MAP_DEPTH_DEF = 1024;
    localparam int UNI_W              = 16;
    localparam int POS_W              = 9;
    localparam int CHAR_W             = 8;
    localparam int ENTRIES_W          = 11;
    localparam int GLYPHS_W           = 10;
    localparam int IDX_W              = 10;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 11;
    localparam int S_TDATA_W          = 56;
    localparam int S_TUSER_W          = 2;
    localparam int M_TDATA_W          = 8;

    localparam logic [CHAR_W-1:0]    FILL_CHAR       = 8'h3F;
    localparam logic [GLYPHS_W-1:0]  GLYPHS_RST      = 10'd256;
    localparam logic [6:0]           DIRECT_HI_LARGE = 7'b1111000;
    localparam logic [7:0]           DIRECT_HI_SMALL = 8'hF0;

    typedef enum logic [1:0] {
        OP_LOAD_CHAR = 2'd0,
        OP_LOAD_FONT = 2'd1,
        OP_BUILD     = 2'd2,
        OP_XLATE     = 2'd3
    } fprt_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FONT_MAP_ENTRIES = 2'd0,
        REG_GLYPH_COUNT      = 2'd1,
        REG_LARGE_FONT       = 2'd2
    } fprt_reg_t;

    typedef enum logic [1:0] {
        WR_FILL   = 2'd0,
        WR_EMPTY  = 2'd1,
        WR_DIRECT = 2'd2,
        WR_HIT    = 2'd3
    } fprt_wr_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_CHR_RD,
        S_CHR_EVAL,
        S_SRCH,
        S_CMP,
        S_NEXT
    } fprt_state_t;

    typedef struct packed {
        logic         accept;
        logic         fill_step;
        logic         chr_init;
        logic         chr_read;
        logic         chr_next;
        logic         srch_init;
        logic         mid_read;
        logic         go_low;
        logic         go_high;
        logic         rev_wr;
        fprt_wr_sel_t wr_sel;
        logic         build_done;
    } fprt_cmd_t;

    typedef struct packed {
        logic stage_full;
        logic fill_last;
        logic chr_last;
        logic map_empty;
        logic empty_ok;
        logic direct_ok;
        logic srch_open;
        logic mu_lt;
        logic mu_gt;
        logic pos_ok;
    } fprt_status_t;

endpackage

// File: hw/rtl/font_position_reverse_translator_unit.sv
// Font position reverse translator: maps screen glyph bytes back to characters.
// Top level; depends on fprt_pkg, fprt_ctrl and fprt_datapath.
//
// Input channel s_*: one item per transfer. s_tuser carries the opcode (load char map
// entry, load font map entry, build, translate). Output channel m_*: exactly one result
// per item, in order; m_tdata is the translated character (zero unless translate),
// m_tuser is the done flag. Config writes (cfg_wr_en/cfg_index/cfg_wdata) only while idle.
// Loads and translates: the result goes through the result stage and the output register
// to m_*, and s_tready is low in the cycle after each transfer, so no new item is taken
// while the last one is still in the result stage. A build first writes the fill
// character into all 512 reverse table entries, then for each of the 256 characters reads
// the char map, evaluates the entry and, when needed, does a binary search of the font map,
// one probe at a time through its single read port. s_tready is low for the whole build.
// Reset (aresetn low, synchronous) clears the configuration to its defaults and makes
// the reverse table read as zero until the first build; maps are undefined until loaded.
// If m_tready is low, one further item is taken into the result stage, then s_tready
// drops until the output register is emptied.
module font_position_reverse_translator_unit
    import fprt_pkg::*;
#(
    parameter int FONT_MAP_DEPTH = FONT_MAP_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index, unicode_value, glyph_position, cell_char, cell_attr, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // char_out
    output logic [M_TDATA_W-1:0]  m_tdata,
    // done_res
    output logic                  m_tuser
);

    fprt_cmd_t    cmd;
    fprt_status_t status;

    fprt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fprt_datapath #(
        .FONT_MAP_DEPTH (FONT_MAP_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: hw/rtl/fprt_ctrl.sv
// Sequencer for the font position reverse translator: handshake and build walk.
// Depends on fprt_pkg; drives fprt_datapath through command/status structs.
module fprt_ctrl
    import fprt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 s_tready,
    input  fprt_status_t         status,
    output fprt_cmd_t            cmd
);

    fprt_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_sel = WR_FILL;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = !status.stage_full;
                cmd.accept = s_tvalid && !status.stage_full;
                if (cmd.accept && (fprt_op_t'(s_tuser) == OP_BUILD)) begin
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                cmd.fill_step = 1'b1;
                cmd.rev_wr    = 1'b1;
                cmd.wr_sel    = WR_FILL;
                if (status.fill_last) begin
                    cmd.chr_init = 1'b1;
                    state_next   = S_CHR_RD;
                end
            end
            S_CHR_RD: begin
                cmd.chr_read = 1'b1;
                state_next   = S_CHR_EVAL;
            end
            S_CHR_EVAL: begin
                if (status.map_empty) begin
                    cmd.rev_wr = status.empty_ok;
                    cmd.wr_sel = WR_EMPTY;
                    state_next = S_NEXT;
                end else if (status.direct_ok) begin
                    cmd.rev_wr = 1'b1;
                    cmd.wr_sel = WR_DIRECT;
                    state_next = S_NEXT;
                end else begin
                    cmd.srch_init = 1'b1;
                    state_next    = S_SRCH;
                end
            end
            S_SRCH: begin
                if (status.srch_open) begin
                    cmd.mid_read = 1'b1;
                    state_next   = S_CMP;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_CMP: begin
                if (status.mu_lt) begin
                    cmd.go_low = 1'b1;
                    state_next = S_SRCH;
                end else if (status.mu_gt) begin
                    cmd.go_high = 1'b1;
                    state_next  = S_SRCH;
                end else begin
                    cmd.rev_wr = status.pos_ok;
                    cmd.wr_sel = WR_HIT;
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (status.chr_last) begin
                    cmd.build_done = 1'b1;
                    state_next     = S_IDLE;
                end else begin
                    cmd.chr_next = 1'b1;
                    state_next   = S_CHR_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/fprt_datapath.sv
// Datapath: config registers, char/font/reverse memories, search registers, output stage.
// Depends on fprt_pkg and the defines header; commanded by fprt_ctrl.
`include "font_position_reverse_translator_unit_defines.svh"

module fprt_datapath
    import fprt_pkg::*;
#(
    parameter int FONT_MAP_DEPTH = FONT_MAP_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser,
    input  fprt_cmd_t             cmd,
    output fprt_status_t          status
);

    localparam int FM_AW = (FONT_MAP_DEPTH > 1) ? $clog2(FONT_MAP_DEPTH) : 1;
    localparam int CNT_W = $clog2(FONT_MAP_DEPTH + 1);

    // input fields
    logic [IDX_W-1:0]  in_index;
    logic [UNI_W-1:0]  in_uni;
    logic [POS_W-1:0]  in_pos;
    logic [CHAR_W-1:0] in_char;
    logic [CHAR_W-1:0] in_attr;
    fprt_op_t          in_op;

    assign in_index = s_tdata[9:0];
    assign in_uni   = s_tdata[25:10];
    assign in_pos   = s_tdata[34:26];
    assign in_char  = s_tdata[42:35];
    assign in_attr  = s_tdata[50:43];
    assign in_op    = fprt_op_t'(s_tuser);

    // configuration
    logic [ENTRIES_W-1:0] entries_reg;
    logic [GLYPHS_W-1:0]  glyphs_reg;
    logic                 large_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= '0;
            glyphs_reg  <= GLYPHS_RST;
            large_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (fprt_reg_t'(cfg_index))
                REG_FONT_MAP_ENTRIES: entries_reg <= cfg_wdata;
                REG_GLYPH_COUNT:      glyphs_reg  <= cfg_wdata[GLYPHS_W-1:0];
                REG_LARGE_FONT:       large_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] map_n;
    assign map_n = (32'(entries_reg) > 32'(FONT_MAP_DEPTH)) ?
                   CNT_W'(FONT_MAP_DEPTH) : CNT_W'(entries_reg);

    // char map
    logic [UNI_W-1:0]  char_mem [CHAR_MAP_DEPTH];
    logic [UNI_W-1:0]  uni_rd_reg;
    logic [CHAR_W-1:0] chr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept && (in_op == OP_LOAD_CHAR) && (in_index < IDX_W'(CHAR_MAP_DEPTH))) begin
            char_mem[in_index[CHAR_W-1:0]] <= in_uni;
        end
        if (cmd.chr_read) begin
            uni_rd_reg <= char_mem[chr_cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chr_cnt_reg <= '0;
        end else if (cmd.chr_init) begin
            chr_cnt_reg <= '1;
        end else if (cmd.chr_next) begin
            chr_cnt_reg <= chr_cnt_reg - 1'b1;
        end
    end

    // font map: unicode in the upper bits, glyph position in the lower
    logic [UNI_W+POS_W-1:0] font_mem [FONT_MAP_DEPTH];
    logic [UNI_W+POS_W-1:0] font_rd_reg;
    logic [FM_AW-1:0]       mid_reg;
    logic [CNT_W-1:0]       lo_reg;
    logic [CNT_W-1:0]       hi_ex_reg;
    logic [CNT_W:0]         mid_sum;
    logic [FM_AW-1:0]       mid;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_ex_reg} - 1'b1;
    assign mid     = FM_AW'(mid_sum[CNT_W:1]);

    always_ff @(posedge aclk) begin
        if (cmd.accept && (in_op == OP_LOAD_FONT) &&
            (32'(in_index) < 32'(FONT_MAP_DEPTH))) begin
            font_mem[FM_AW'(in_index)] <= {in_uni, in_pos};
        end
        if (cmd.mid_read) begin
            font_rd_reg <= font_mem[mid];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg    <= '0;
            hi_ex_reg <= '0;
            mid_reg   <= '0;
        end else begin
            if (cmd.srch_init) begin
                lo_reg    <= '0;
                hi_ex_reg <= map_n;
            end else if (cmd.go_low) begin
                lo_reg <= CNT_W'(mid_reg) + 1'b1;
            end else if (cmd.go_high) begin
                hi_ex_reg <= CNT_W'(mid_reg);
            end
            if (cmd.mid_read) begin
                mid_reg <= mid;
            end
        end
    end

    logic [UNI_W-1:0] mu;
    logic [POS_W-1:0] mp;
    assign mu = font_rd_reg[UNI_W+POS_W-1:POS_W];
    assign mp = font_rd_reg[POS_W-1:0];

    // reverse table; built_reg stands for the all-zero reset contents
    logic [CHAR_W-1:0] rev_mem [REV_DEPTH];
    logic [CHAR_W-1:0] rev_rd_reg;
    logic [REV_AW-1:0] fill_cnt_reg;
    logic              built_reg;
    logic [REV_AW-1:0] rev_addr;
    logic [CHAR_W-1:0] rev_data;
    logic [REV_AW-1:0] direct_pos;
    logic [REV_AW-1:0] xlate_addr;

    assign direct_pos = large_reg ? uni_rd_reg[POS_W-1:0] : {1'b0, uni_rd_reg[CHAR_W-1:0]};
    assign xlate_addr = {large_reg & in_attr[3], in_char};

    always_comb begin
        rev_data = chr_cnt_reg;
        case (cmd.wr_sel)
            WR_FILL: begin
                rev_addr = fill_cnt_reg;
                rev_data = FILL_CHAR;
            end
            WR_EMPTY:  rev_addr = {1'b0, uni_rd_reg[CHAR_W-1:0]};
            WR_DIRECT: rev_addr = direct_pos;
            default:   rev_addr = mp;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.rev_wr) begin
            rev_mem[rev_addr] <= rev_data;
        end
        if (cmd.accept && (in_op == OP_XLATE)) begin
            rev_rd_reg <= rev_mem[xlate_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg <= '0;
            built_reg    <= 1'b0;
        end else if (cmd.accept && (in_op == OP_BUILD)) begin
            fill_cnt_reg <= '0;
            built_reg    <= 1'b1;
        end else if (cmd.fill_step) begin
            fill_cnt_reg <= fill_cnt_reg + 1'b1;
        end
    end

    // result stage and output register
    logic              st_valid_reg;
    logic              st_xlate_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              st_move;

    assign st_move = st_valid_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            st_xlate_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept && (in_op != OP_BUILD)) begin
                st_valid_reg <= 1'b1;
                st_xlate_reg <= (in_op == OP_XLATE);
            end else if (cmd.build_done) begin
                st_valid_reg <= 1'b1;
                st_xlate_reg <= 1'b0;
            end else if (st_move) begin
                st_valid_reg <= 1'b0;
            end
            if (st_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_move) begin
            out_char_reg <= (st_xlate_reg && built_reg) ? rev_rd_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = 1'b1;

    // status
    assign status.stage_full = st_valid_reg;
    assign status.fill_last  = (fill_cnt_reg == REV_AW'(REV_DEPTH - 1));
    assign status.chr_last   = (chr_cnt_reg == '0);
    assign status.map_empty  = (entries_reg == '0);
    assign status.empty_ok   = (uni_rd_reg[UNI_W-1:CHAR_W] == '0);
    assign status.direct_ok  = large_reg ? (uni_rd_reg[UNI_W-1:POS_W] == DIRECT_HI_LARGE)
                                         : (uni_rd_reg[UNI_W-1:CHAR_W] == DIRECT_HI_SMALL);
    assign status.srch_open  = (lo_reg < hi_ex_reg);
    assign status.mu_lt      = (mu < uni_rd_reg);
    assign status.mu_gt      = (mu > uni_rd_reg);
    assign status.pos_ok     = ({1'b0, mp} < glyphs_reg);

    `FPRT_ASSERT(a_no_accept_when_full, cmd.accept |-> !st_valid_reg, "item taken over a full stage")
    `FPRT_ASSERT(a_search_window, (lo_reg <= hi_ex_reg) && (hi_ex_reg <= CNT_W'(FONT_MAP_DEPTH)), "search window broken")
    `FPRT_ASSERT(a_build_result_last, cmd.build_done |-> (chr_cnt_reg == '0) && built_reg, "early build result")
    `FPRT_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !out_valid_reg && !st_valid_reg, "result after reset")

endmodule
